[hdl/s16dec_pkg.sv]
package s16dec_pkg;

  // Field widths
  localparam int unsigned ValueW    = 16;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned PosW      = 3;

  // Divide by ten: q = (m * 0xCCCD) >> 19, exact for every 16-bit m
  localparam int unsigned ProdW      = 33;
  localparam int unsigned RecipShift = 19;
  localparam logic [16:0] Recip10    = 17'h0CCCD;
  localparam logic [ValueW-1:0] Ten  = 16'd10;

  // Character codes
  localparam logic [CharW-1:0] DigitBase = 8'd48;
  localparam logic [CharW-1:0] MinusCode = 8'd45;

  typedef logic [DigitW-1:0] digit_t;

  // Item in flight: sign, remaining quotient, digits collected so far
  typedef struct packed {
    logic                        neg;
    logic [ValueW-1:0]           rem;
    digit_t [NumDigits-1:0]      dig;
  } work_t;

  // One decimal digit off the bottom; the new digit enters at the top and
  // the older ones shift down, so after five steps dig[0] is the units digit.
  function automatic work_t digit_step(work_t w);
    logic [ProdW-1:0]  prod;
    logic [ValueW-1:0] q;
    logic [ValueW-1:0] r;
    work_t             o;
    prod  = ProdW'(w.rem) * ProdW'(Recip10);
    q     = ValueW'(prod >> RecipShift);
    r     = w.rem - ValueW'(q * Ten);
    o.neg = w.neg;
    o.rem = q;
    o.dig = {r[DigitW-1:0], w.dig[NumDigits-1:1]};
    return o;
  endfunction

endpackage

[hdl/s16dec_if.sv]
// Input channel: one signed value per request
interface s16dec_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [s16dec_pkg::ValueW-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one character per request
interface s16dec_out_if;
  logic                            valid;
  logic                            ready;
  logic [s16dec_pkg::CharW-1:0]    char_code;
  logic                            last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[hdl/s16dec_digit_stage.sv]
// One pipeline stage: peels one decimal digit off the remaining quotient
module s16dec_digit_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  s16dec_pkg::work_t   data_i,
  output logic                ready_o,
  output logic                valid_o,
  output s16dec_pkg::work_t   data_o,
  input  logic                ready_i
);

  logic              valid_q;
  s16dec_pkg::work_t data_q;

  // Stage takes a new request when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= s16dec_pkg::digit_step(data_i);
    end
  end

endmodule

[hdl/s16dec_serializer.sv]
// Holds one converted value and sends its text one character per request
module s16dec_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  s16dec_pkg::work_t   data_i,
  output logic                ready_o,
  s16dec_out_if.source        out_o
);

  logic                                          busy_q;
  logic                                          sign_q;
  logic [s16dec_pkg::PosW-1:0]                   pos_q;
  s16dec_pkg::digit_t [s16dec_pkg::NumDigits-1:0] dig_q;
  logic [s16dec_pkg::PosW-1:0]                   top_pos;
  logic                                          fire;
  logic                                          done;

  // Highest nonzero digit; zero keeps a single units digit
  always_comb begin
    top_pos = '0;
    for (int i = 1; i < s16dec_pkg::NumDigits; i++) begin
      if (data_i.dig[i] != '0) begin
        top_pos = s16dec_pkg::PosW'(i);
      end
    end
  end

  // Sign first, then digits from the top down to the units
  assign out_o.valid     = busy_q;
  assign out_o.char_code = sign_q ? s16dec_pkg::MinusCode
                                  : s16dec_pkg::DigitBase +
                                    s16dec_pkg::CharW'(dig_q[pos_q]);
  assign out_o.last_char = !sign_q && (pos_q == '0);

  assign fire    = busy_q && out_o.ready;
  assign done    = fire && out_o.last_char;
  assign ready_o = !busy_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      pos_q  <= '0;
    end else if (ready_o) begin
      busy_q <= valid_i;
      if (valid_i) begin
        sign_q <= data_i.neg;
        pos_q  <= top_pos;
      end
    end else if (fire) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        pos_q <= pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dig_q <= data_i.dig;
    end
  end

endmodule

[hdl/signed_int16_to_decimal_ascii_core.sv]
// Signed 16-bit to decimal ASCII converter. Each value taken on in_i leaves
// on out_o as its decimal text, one character per request, most significant
// first: '-' for negative values, no leading zeros, '0' for zero, and the
// final character flagged by last_char. -32768 gives "-32768". A value runs
// through six register stages (sign/magnitude, then one divide-by-ten stage
// per digit, each a constant multiply) before it reaches the character
// serializer. The serializer sends one character per cycle while out_o is
// ready, so a value holds it for as many characters as its text has, 1 to 6;
// that sets the sustained rate. The pipeline ahead of it keeps accepting
// values until its stages are full.
module signed_int16_to_decimal_ascii_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  s16dec_in_if.sink     in_i,
  s16dec_out_if.source  out_o
);

  localparam int unsigned NumStages = s16dec_pkg::NumDigits;

  logic                v0_q;
  s16dec_pkg::work_t   w0_q;
  logic                in_ready;
  logic [s16dec_pkg::ValueW-1:0] mag;

  logic              vld [NumStages+1];
  s16dec_pkg::work_t dat [NumStages+1];
  logic              rdy [NumStages+1];

  // Input stage: split sign and magnitude (-32768 maps to 32768)
  assign mag      = in_i.value[s16dec_pkg::ValueW-1] ? (~in_i.value + 1'b1) : in_i.value;
  assign in_ready = !v0_q || rdy[0];
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (in_ready) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      w0_q.neg <= in_i.value[s16dec_pkg::ValueW-1];
      w0_q.rem <= mag;
      w0_q.dig <= '0;
    end
  end

  assign vld[0] = v0_q;
  assign dat[0] = w0_q;

  // One digit per stage
  for (genvar g = 0; g < NumStages; g++) begin : g_digit
    s16dec_digit_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .data_i  (dat[g]),
      .ready_o (rdy[g]),
      .valid_o (vld[g+1]),
      .data_o  (dat[g+1]),
      .ready_i (rdy[g+1])
    );
  end

  // Character output
  s16dec_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[NumStages]),
    .data_i  (dat[NumStages]),
    .ready_o (rdy[NumStages]),
    .out_o   (out_o)
  );

endmodule

[hdl/s16dec_checker.sv]
// Port-level checks on the character stream
module s16dec_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [s16dec_pkg::CharW-1:0]   char_code_i,
  input logic                           last_char_i
);

  // A stalled character holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_code_i) && $stable(last_char_i))
    else $error("stalled character changed");

  // Only '-' or a digit ever shows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (char_code_i == s16dec_pkg::MinusCode) ||
                    ((char_code_i >= s16dec_pkg::DigitBase) &&
                     (char_code_i <= s16dec_pkg::DigitBase + 8'd9)))
    else $error("bad character code");

  // The sign never ends a text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (char_code_i == s16dec_pkg::MinusCode) |-> !last_char_i)
    else $error("sign flagged as last");

  // Text continues without a gap, and a sign is followed by a nonzero digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_char_i |=> out_valid_i)
    else $error("gap inside a text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (char_code_i == s16dec_pkg::MinusCode) |=>
      (char_code_i != s16dec_pkg::MinusCode) && (char_code_i != s16dec_pkg::DigitBase))
    else $error("bad character after sign");

endmodule

bind signed_int16_to_decimal_ascii_core s16dec_checker u_s16dec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .char_code_i (out_o.char_code),
  .last_char_i (out_o.last_char)
);

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output character
  typedef struct packed {
    logic [s16dec_pkg::CharW-1:0] code;
    logic                         last;
  } text_char_t;

  // Expected decimal text of accepted values, checked in order
  class decimal_text_board;
    text_char_t expected_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    // Predict the text of one accepted value and queue its characters
    function void note_value(input logic signed [s16dec_pkg::ValueW-1:0] value);
      logic                              neg;
      logic [s16dec_pkg::ValueW:0]       mag;
      logic [s16dec_pkg::DigitW-1:0]     digs [s16dec_pkg::NumDigits];
      int                                n;
      text_char_t                        ch;
      neg = value[s16dec_pkg::ValueW-1];
      // true magnitude, so -32768 becomes 32768
      mag = neg ? (17'h10000 - {1'b0, value}) : {1'b0, value};
      n = 0;
      do begin
        digs[n] = s16dec_pkg::DigitW'(mag % 10);
        n++;
        mag = (s16dec_pkg::ValueW+1)'(mag / 10);
      end while (mag != 0 && n < s16dec_pkg::NumDigits);
      if (neg) begin
        ch.code = s16dec_pkg::MinusCode;
        ch.last = 1'b0;
        expected_chars.push_back(ch);
      end
      for (int k = n - 1; k >= 0; k--) begin
        ch.code = s16dec_pkg::DigitBase + s16dec_pkg::CharW'(digs[k]);
        ch.last = (k == 0);
        expected_chars.push_back(ch);
      end
    endfunction

    // Compare one accepted character with the oldest expected one
    task check_char(input logic [s16dec_pkg::CharW-1:0] code, input logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last=%0b", code, last));
      end else begin
        want = expected_chars.pop_front();
        if (code !== want.code)
          report($sformatf("char_code 0x%02h, expected 0x%02h", code, want.code));
        if (last !== want.last)
          report($sformatf("last_char %0b, expected %0b (char 0x%02h)",
                           last, want.last, want.code));
      end
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  s16dec_in_if  in_ch ();
  s16dec_out_if out_ch ();

  signed_int16_to_decimal_ascii_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  decimal_text_board text_board;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one value, with random idle cycles first, and wait for acceptance
  task automatic send_value(input logic signed [s16dec_pkg::ValueW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    text_board.note_value(value);
  endtask

  // Random value: full range, small, near the extremes, or at or just below a power of ten
  function automatic logic signed [s16dec_pkg::ValueW-1:0] random_value();
    logic signed [s16dec_pkg::ValueW-1:0] v;
    int                                   p10 [5];
    p10 = '{1, 10, 100, 1000, 10000};
    case ($urandom_range(4))
      0, 1:    v = s16dec_pkg::ValueW'($urandom);
      2:       v = s16dec_pkg::ValueW'($urandom_range(40)) - 16'sd20;
      3:       v = $urandom_range(1) ?
                     (16'sh7FFF - s16dec_pkg::ValueW'($urandom_range(3))) :
                     (16'sh8000 + s16dec_pkg::ValueW'($urandom_range(3)));
      default: begin
        v = s16dec_pkg::ValueW'(p10[$urandom_range(4)]) -
            s16dec_pkg::ValueW'($urandom_range(1));
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Receiver: check accepted characters, then choose ready for the next cycle
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        text_board.check_char(out_ch.char_code, out_ch.last_char);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    #(200_000 * 10);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    logic signed [s16dec_pkg::ValueW-1:0] directed [$];
    text_board     = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    rst_n          = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, extremes, digit-count boundaries, both signs
    directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd9, 16'sd10, -16'sd9, -16'sd10,
                 16'sd99, 16'sd100, -16'sd100, 16'sd999, 16'sd1000, 16'sd9999,
                 16'sd10000, -16'sd10000, 16'sh7FFF, 16'sh8000, -16'sd32767,
                 16'sd12345, -16'sd12345, 16'sd20000, -16'sd5};
    foreach (directed[i]) send_value(directed[i]);

    // Random phases with different idle patterns
    repeat (70) send_value(random_value());
    send_idle_pct = 56;
    repeat (70) send_value(random_value());
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    repeat (62) send_value(random_value());
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    repeat (62) send_value(random_value());

    // Long receiver hold-off while values keep coming: input must back up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 300;
    repeat (24) send_value(random_value());
    in_ch.valid <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (text_board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (text_board.mismatches == 0 && text_board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
